### rtl/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg: shared types and constants for the Newton square root block
// Holds the fixed-point format, the step limit, the result codes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package nsr_pkg;

  localparam int FRAC_BITS = 48;   // fraction bits of an estimate
  localparam int MAX_ITER  = 100;  // step limit
  localparam int EST_W     = 64;   // estimate width
  localparam int WIDE_W    = 192;  // numerator and quotient width of the divider
  localparam int X_W       = 31;   // radicand width
  localparam int E_W       = 4;    // digit count width
  localparam int STEPS_W   = 7;    // reported step count width
  localparam int SCNT_W    = 8;    // internal step counter, holds MAX_ITER + 1
  localparam int DCNT_W    = 8;    // divider bit counter
  localparam int ISQ_STEPS = 16;   // digit pairs of the start square root
  localparam int MUL_STEPS = 5;    // four partial products plus a final drain step

  typedef enum logic [1:0] {
    RES_CONVERGED = 2'd0,
    RES_INVALID   = 2'd1,
    RES_NO_CONV   = 2'd2
  } res_status_t;

  typedef struct packed {
    logic        load_in;
    logic        isq_step;
    logic        start_est;
    logic        div_start;
    logic        div_sel_tol;
    logic        tol_capture;
    logic        avg;
    logic        mul_step;
    logic [2:0]  mul_idx;
    logic        diff_calc;
    logic        step_inc;
    logic        out_load;
    res_status_t out_status;
  } cmd_t;

  typedef struct packed {
    logic in_invalid;
    logic div_done;
    logic limit;
    logic converged;
  } stat_t;

  // Powers of ten for the tolerance.
  function automatic logic [EST_W-1:0] pow10(input logic [E_W-1:0] e);
    logic [EST_W-1:0] p;
    case (e)
      4'd0:    p = 64'd1;
      4'd1:    p = 64'd10;
      4'd2:    p = 64'd100;
      4'd3:    p = 64'd1000;
      4'd4:    p = 64'd10000;
      4'd5:    p = 64'd100000;
      4'd6:    p = 64'd1000000;
      4'd7:    p = 64'd10000000;
      4'd8:    p = 64'd100000000;
      4'd9:    p = 64'd1000000000;
      4'd10:   p = 64'd10000000000;
      4'd11:   p = 64'd100000000000;
      4'd12:   p = 64'd1000000000000;
      4'd13:   p = 64'd10000000000000;
      4'd14:   p = 64'd100000000000000;
      default: p = 64'd1000000000000000;
    endcase
    return p;
  endfunction

endpackage

### rtl/nsr_div.sv
// ----------------------------------------------------------------------------
// nsr_div: iterative restoring divider
// Divides a 192-bit numerator by a 64-bit divisor, one quotient bit a cycle.
// A zero divisor gives an all-ones quotient at once.
// ----------------------------------------------------------------------------
module nsr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [nsr_pkg::WIDE_W-1:0] num,
  input  logic [nsr_pkg::EST_W-1:0]  den,
  output logic                       done,
  output logic [nsr_pkg::WIDE_W-1:0] quot
);

  logic                       busy_r;
  logic                       done_r;
  logic [nsr_pkg::DCNT_W-1:0] cnt_r;
  logic [nsr_pkg::WIDE_W-1:0] num_r;
  logic [nsr_pkg::WIDE_W-1:0] quot_r;
  logic [nsr_pkg::EST_W-1:0]  den_r;
  logic [nsr_pkg::EST_W-1:0]  rem_r;
  logic [nsr_pkg::EST_W-1:0]  rem_nxt;
  logic [nsr_pkg::EST_W:0]    shifted;
  logic                       ge;

  always_comb begin
    shifted = {rem_r, num_r[nsr_pkg::WIDE_W-1]};
    ge      = (shifted >= {1'b0, den_r});
    if (ge) begin
      rem_nxt = nsr_pkg::EST_W'(shifted - {1'b0, den_r});
    end else begin
      rem_nxt = shifted[nsr_pkg::EST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= '0;
        if (den == '0) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == nsr_pkg::DCNT_W'(nsr_pkg::WIDE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      quot_r <= (den == '0) ? '1 : '0;
    end else if (busy_r) begin
      num_r  <= {num_r[nsr_pkg::WIDE_W-2:0], 1'b0};
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[nsr_pkg::WIDE_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### rtl/nsr_dp.sv
// ----------------------------------------------------------------------------
// nsr_dp: datapath of the Newton square root
// Start square root, tolerance, Newton update, split square and error test.
// ----------------------------------------------------------------------------
module nsr_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [nsr_pkg::X_W-1:0]     radicand,
  input  logic [nsr_pkg::E_W-1:0]     digits,
  input  nsr_pkg::cmd_t               cmd,
  output nsr_pkg::stat_t              stat,
  output logic [1:0]                  res_status,
  output logic [nsr_pkg::EST_W-1:0]   res_root,
  output logic [nsr_pkg::STEPS_W-1:0] res_steps
);

  localparam int TWO_F = 2 * nsr_pkg::FRAC_BITS;

  logic [nsr_pkg::X_W-1:0]     x_r;
  logic [nsr_pkg::E_W-1:0]     e_r;
  logic [31:0]                 v_r;
  logic [31:0]                 res_r;
  logic [31:0]                 bit_r;
  logic [nsr_pkg::EST_W-1:0]   est_r;
  logic [nsr_pkg::WIDE_W-1:0]  tol_r;
  logic [63:0]                 prod_r;
  logic [1:0]                  sh_r;
  logic [127:0]                sq_r;
  logic [nsr_pkg::WIDE_W-1:0]  diff_r;
  logic [nsr_pkg::SCNT_W-1:0]  step_r;
  logic [1:0]                  status_r;
  logic [nsr_pkg::EST_W-1:0]   root_r;
  logic [nsr_pkg::STEPS_W-1:0] steps_r;

  logic [31:0]                 trial;
  logic [31:0]                 xm1;
  logic [15:0]                 s;
  logic [31:0]                 s_sq;
  logic [16:0]                 start_k;
  logic [nsr_pkg::EST_W-1:0]   start_w;
  logic [nsr_pkg::EST_W-1:0]   start_est;
  logic [nsr_pkg::EST_W-1:0]   p;
  logic [nsr_pkg::WIDE_W-1:0]  xn;
  logic [nsr_pkg::WIDE_W-1:0]  tol_num;
  logic [nsr_pkg::WIDE_W-1:0]  div_num;
  logic [nsr_pkg::WIDE_W-1:0]  quot;
  logic                        div_done;
  logic [nsr_pkg::EST_W-1:0]   b;
  logic [nsr_pkg::EST_W:0]     sum;
  logic [31:0]                 ma;
  logic [31:0]                 mb;
  logic [1:0]                  msh;
  logic [127:0]                prod_sh;
  logic [nsr_pkg::WIDE_W-1:0]  sq_w;

  always_comb begin
    trial   = res_r + bit_r;
    xm1     = 32'(x_r) - 32'd1;
    s       = res_r[15:0];
    s_sq    = s * s;
    start_k = {1'b0, s} + ((s_sq != xm1) ? 17'd1 : 17'd0);
    start_w = nsr_pkg::EST_W'(start_k - 17'd1);
    if ((start_w >> (nsr_pkg::EST_W - nsr_pkg::FRAC_BITS)) != '0) begin
      start_est = '1;
    end else begin
      start_est = start_w << nsr_pkg::FRAC_BITS;
    end
    p       = nsr_pkg::pow10(e_r);
    xn      = nsr_pkg::WIDE_W'(x_r) << TWO_F;
    tol_num = (nsr_pkg::WIDE_W'(1) << TWO_F) + nsr_pkg::WIDE_W'(p >> 1);
    div_num = cmd.div_sel_tol ? tol_num : xn;
    b       = (quot[nsr_pkg::WIDE_W-1:nsr_pkg::EST_W] != '0) ? '1
                                                            : quot[nsr_pkg::EST_W-1:0];
    sum     = {1'b0, est_r} + {1'b0, b};
    case (cmd.mul_idx)
      3'd0:    begin ma = est_r[31:0];  mb = est_r[31:0];  msh = 2'd0; end
      3'd1:    begin ma = est_r[31:0];  mb = est_r[63:32]; msh = 2'd1; end
      3'd2:    begin ma = est_r[63:32]; mb = est_r[31:0];  msh = 2'd1; end
      default: begin ma = est_r[63:32]; mb = est_r[63:32]; msh = 2'd2; end
    endcase
    prod_sh = 128'(prod_r) << {sh_r, 5'd0};
    sq_w    = nsr_pkg::WIDE_W'(sq_r);
  end

  nsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (cmd.div_sel_tol ? p : est_r),
    .done  (div_done),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x_r   <= radicand;
      e_r   <= digits;
      v_r   <= 32'(radicand) - 32'd1;
      res_r <= '0;
      bit_r <= 32'd1 << 30;
    end
    if (cmd.isq_step) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.start_est) begin
      est_r  <= start_est;
      step_r <= nsr_pkg::SCNT_W'(1);
    end
    if (cmd.tol_capture) begin
      tol_r <= quot;
    end
    if (cmd.avg) begin
      est_r <= sum[nsr_pkg::EST_W:1];
    end
    if (cmd.mul_step) begin
      if (cmd.mul_idx != 3'd4) begin
        prod_r <= ma * mb;
        sh_r   <= msh;
      end
      if (cmd.mul_idx == 3'd0) begin
        sq_r <= '0;
      end else begin
        sq_r <= sq_r + prod_sh;
      end
    end
    if (cmd.diff_calc) begin
      diff_r <= (xn >= sq_w) ? (xn - sq_w) : (sq_w - xn);
    end
    if (cmd.step_inc) begin
      step_r <= step_r + 1'b1;
    end
    if (cmd.out_load) begin
      status_r <= cmd.out_status;
      if (cmd.out_status == nsr_pkg::RES_INVALID) begin
        root_r  <= '0;
        steps_r <= '0;
      end else begin
        root_r  <= est_r;
        steps_r <= (step_r > nsr_pkg::SCNT_W'(127)) ? '1 : step_r[nsr_pkg::STEPS_W-1:0];
      end
    end
  end

  always_comb begin
    stat.in_invalid = (radicand <= nsr_pkg::X_W'(1)) || (digits == '0);
    stat.div_done   = div_done;
    stat.limit      = (step_r > nsr_pkg::SCNT_W'(nsr_pkg::MAX_ITER));
    stat.converged  = (diff_r < tol_r);
  end

  assign res_status = status_r;
  assign res_root   = root_r;
  assign res_steps  = steps_r;

endmodule

### rtl/nsr_ctrl.sv
// ----------------------------------------------------------------------------
// nsr_ctrl: sequencer of the Newton square root
// Steps the datapath through start estimate, tolerance and Newton steps.
// ----------------------------------------------------------------------------
module nsr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  nsr_pkg::stat_t stat,
  output nsr_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_ISQ, S_START, S_TOL, S_NDIV, S_MUL, S_DIFF, S_CMP, S_FINISH
  } state_t;

  state_t               state_r;
  logic [3:0]           cnt_r;
  nsr_pkg::res_status_t res_r;
  logic                 out_valid_r;
  logic                 accept;
  logic                 out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      res_r       <= nsr_pkg::RES_CONVERGED;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          cnt_r <= '0;
          if (accept) begin
            if (stat.in_invalid) begin
              res_r   <= nsr_pkg::RES_INVALID;
              state_r <= S_FINISH;
            end else begin
              state_r <= S_ISQ;
            end
          end
        end
        S_ISQ: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 4'(nsr_pkg::ISQ_STEPS - 1)) begin
            state_r <= S_START;
          end
        end
        S_START: state_r <= S_TOL;
        S_TOL: begin
          if (stat.div_done) begin
            state_r <= S_NDIV;
          end
        end
        S_NDIV: begin
          cnt_r <= '0;
          if (stat.div_done) begin
            if (stat.limit) begin
              res_r   <= nsr_pkg::RES_NO_CONV;
              state_r <= S_FINISH;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == 4'(nsr_pkg::MUL_STEPS - 1)) begin
            state_r <= S_DIFF;
          end
        end
        S_DIFF: state_r <= S_CMP;
        S_CMP: begin
          if (stat.converged) begin
            res_r   <= nsr_pkg::RES_CONVERGED;
            state_r <= S_FINISH;
          end else begin
            state_r <= S_NDIV;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.out_status  = res_r;
    cmd.mul_idx     = cnt_r[2:0];
    cmd.load_in     = accept;
    cmd.isq_step    = (state_r == S_ISQ);
    cmd.start_est   = (state_r == S_START);
    cmd.mul_step    = (state_r == S_MUL);
    cmd.diff_calc   = (state_r == S_DIFF);
    cmd.out_load    = (state_r == S_FINISH) && out_free;
    cmd.div_sel_tol = (state_r == S_START);
    cmd.tol_capture = (state_r == S_TOL) && stat.div_done;
    cmd.avg         = (state_r == S_NDIV) && stat.div_done;
    cmd.step_inc    = (state_r == S_CMP) && !stat.converged;
    cmd.div_start   = (state_r == S_START) || cmd.tol_capture || cmd.step_inc;
  end

endmodule

### rtl/newton_square_root_top.sv
// ----------------------------------------------------------------------------
// newton_square_root_top: fixed-point Newton square root
// Takes an integer radicand and a digit count and returns the root in Q16.48.
// ----------------------------------------------------------------------------
// One beat in gives one beat out. A radicand of 0 or 1, or a digit count of
// 0, is rejected at once with status 1 and zero root and steps. Otherwise the
// start estimate ceil(sqrt(x-1))-1 is found by a digit-pair square root, the
// tolerance 10^-e (rounded to 96 fraction bits) by one pass of the divider,
// and then each Newton step takes one pass of the shared bit-serial divider,
// a split 32x32 squaring and an error test. The number of steps is reported
// in the result (at most 101); when the step limit is reached the last step
// skips the squaring and the test. The block takes one item at a time; a
// finished result waits in the output register and a new beat is accepted
// while it waits.
// ----------------------------------------------------------------------------
module newton_square_root_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // radicand [30:0], digits [34:31], zeros above
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // root [63:0], steps [70:64], zero at the top
  output logic [1:0]  out_tuser   // status [1:0]
);

  nsr_pkg::cmd_t  cmd;
  nsr_pkg::stat_t stat;
  logic [nsr_pkg::EST_W-1:0]   res_root;
  logic [nsr_pkg::STEPS_W-1:0] res_steps;

  // Sequencer: handshakes and the order of the work.
  nsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Datapath: all arithmetic and the output register.
  nsr_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .radicand   (in_tdata[30:0]),
    .digits     (in_tdata[34:31]),
    .cmd        (cmd),
    .stat       (stat),
    .res_status (out_tuser),
    .res_root   (res_root),
    .res_steps  (res_steps)
  );

  assign out_tdata = {1'b0, res_steps, res_root};

endmodule

### dv/tb_newton_square_root_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_newton_square_root_top: self-checking bench for the Newton square root
// Drives radicand and digit count beats, predicts status, root and step count
// with a fixed-point Newton model of its own, and checks every result beat.
// ----------------------------------------------------------------------------
module tb_newton_square_root_top;

  // The limit allows many of the slowest items and every stall on top.
  localparam longint CYCLE_LIMIT = 40_000_000;

  typedef struct packed {
    nsr_pkg::res_status_t status;
    logic [63:0] root;
    logic [6:0]  steps;
  } root_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // radicand [30:0], digits [34:31], zeros above
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;       // root [63:0], steps [70:64], zero at the top
  logic [1:0]  out_tuser;       // status [1:0]

  root_res_t   expected_roots[$];
  int          mismatches = 0;
  longint      cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;

  newton_square_root_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #6 clk = ~clk;

  // Newton iteration at the block's widths: Q16.48 estimates, a 192-bit
  // quotient that saturates to 64 bits, and a full 128-bit square compared
  // with the radicand scaled by 2^96.
  function automatic root_res_t predict_root(input logic [30:0] x, input logic [3:0] e);
    logic [31:0]  v;
    logic [31:0]  acc;
    logic [31:0]  probe;
    logic [31:0]  k;
    logic [31:0]  start;
    logic [63:0]  est;
    logic [63:0]  b;
    logic [63:0]  p10;
    logic [191:0] xn;
    logic [191:0] tol;
    logic [191:0] q;
    logic [191:0] sq;
    logic [191:0] diff;
    int           steps;
    root_res_t    r;
    r = '0;
    if (x <= 1 || e == 0) begin
      r.status = nsr_pkg::RES_INVALID;
      return r;
    end
    // Exact integer square root of x-1, two bits at a time.
    v = {1'b0, x} - 32'd1;
    acc = 0;
    probe = 32'd1 << 30;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= acc + probe) begin
        v = v - (acc + probe);
        acc = (acc >> 1) + probe;
      end else begin
        acc = acc >> 1;
      end
      probe = probe >> 2;
    end
    k = acc + ((acc * acc != {1'b0, x} - 32'd1) ? 32'd1 : 32'd0);
    start = k - 1;
    if ((64'(start) >> (64 - nsr_pkg::FRAC_BITS)) != 0) est = '1;
    else est = 64'(start) << nsr_pkg::FRAC_BITS;
    p10 = 64'd1;
    for (int i = 0; i < e; i++) p10 = p10 * 64'd10;
    xn = 192'(x) << (2 * nsr_pkg::FRAC_BITS);
    tol = ((192'd1 << (2 * nsr_pkg::FRAC_BITS)) + 192'(p10 >> 1)) / 192'(p10);
    steps = 1;
    forever begin
      if (est == 0) q = '1;
      else q = xn / 192'(est);
      b = (q[191:64] != 0) ? '1 : q[63:0];
      est = (est >> 1) + (b >> 1) + 64'(est[0] & b[0]);
      if (steps > nsr_pkg::MAX_ITER) begin
        r.status = nsr_pkg::RES_NO_CONV;
        break;
      end
      sq = 192'(est) * 192'(est);
      diff = (xn >= sq) ? xn - sq : sq - xn;
      if (diff < tol) begin
        r.status = nsr_pkg::RES_CONVERGED;
        break;
      end
      steps++;
    end
    r.root = est;
    r.steps = (steps > 127) ? 7'd127 : 7'(steps);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Sends one beat after a random number of idle cycles. Valid is left high
  // after acceptance so back-to-back beats need no second assignment.
  task automatic send_radicand(input logic [30:0] x, input logic [3:0] e);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, e, x};
    do @(posedge clk); while (!(in_tvalid && in_tready));
    expected_roots.push_back(predict_root(x, e));
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Holds the sender back until every result has come out.
  task automatic wait_drained();
    go_idle();
    while (expected_roots.size() != 0) @(posedge clk);
  endtask

  // Receiver stall pattern, changed at the falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("[newton_square_root_top] ERROR");
      $finish;
    end
  end

  // Each accepted result beat is checked against the oldest prediction.
  always @(posedge clk) begin
    root_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_roots.size() == 0) begin
        report_mismatch("unexpected beat", out_tdata[63:0], '0);
      end else begin
        want = expected_roots.pop_front();
        if (out_tuser != want.status)
          report_mismatch("status", 64'(out_tuser), 64'(want.status));
        if (out_tdata[63:0] != want.root)
          report_mismatch("root", out_tdata[63:0], want.root);
        if (out_tdata[70:64] != want.steps)
          report_mismatch("steps", 64'(out_tdata[70:64]), 64'(want.steps));
      end
    end
  end

  // Extremes of both fields, rejected inputs, the zero start estimate of
  // x = 2, perfect squares and the tightest tolerance, which runs into the
  // step limit for large radicands.
  task automatic test_directed();
    send_radicand(31'd0, 4'd5);
    send_radicand(31'd1, 4'd1);
    send_radicand(31'd1, 4'd15);
    send_radicand(31'd5, 4'd0);
    send_radicand(31'd0, 4'd0);
    send_radicand(31'h7FFFFFFF, 4'd0);
    send_radicand(31'd2, 4'd1);
    send_radicand(31'd2, 4'd15);
    send_radicand(31'd3, 4'd2);
    send_radicand(31'd4, 4'd3);
    send_radicand(31'd16, 4'd6);
    send_radicand(31'd17, 4'd4);
    send_radicand(31'h7FFFFFFF, 4'd1);
    send_radicand(31'h7FFFFFFF, 4'd15);
    send_radicand(31'h40000000, 4'd8);
    send_radicand(31'd1000000, 4'd10);
    send_radicand(31'h55555555, 4'd12);
    send_radicand(31'd2147395600, 4'd7);
    wait_drained();
  endtask

  // Mostly valid items with small radicands and loose tolerances, some full
  // range values and near squares, a few tight tolerances and rejects.
  task automatic test_random(input int count);
    logic [30:0] x;
    logic [3:0]  e;
    int          pick;
    int          root_int;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 50) x = 31'($urandom_range(1000, 2));
      else if (pick < 80) x = 31'($urandom_range(31'h7FFFFFFF, 2));
      else begin
        root_int = $urandom_range(46340, 2);
        x = 31'(root_int * root_int + $urandom_range(2) - 1);
      end
      e = ($urandom_range(99) < 88) ? 4'($urandom_range(7, 1)) : 4'($urandom_range(15, 8));
      pick = $urandom_range(99);
      if (pick < 4) x = 31'($urandom_range(1));
      else if (pick < 8) e = 4'd0;
      send_radicand(x, e);
      if (n == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 13;
    recv_idle_pct = 56;
    test_directed();
    test_random(200);

    send_idle_pct = 56;
    recv_idle_pct = 13;
    test_random(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(200);

    go_idle();
    while (expected_roots.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("[newton_square_root_top] OK");
    end else begin
      $display("[newton_square_root_top] ERROR");
    end
    $finish;
  end

endmodule

### files.f
rtl/nsr_pkg.sv
rtl/nsr_div.sv
rtl/nsr_dp.sv
rtl/nsr_ctrl.sv
rtl/newton_square_root_top.sv
dv/tb_newton_square_root_top.sv
